FILE: rtl/core/mts_pkg.sv
package mts_pkg;

	localparam int unsigned STACK_ENTRIES_DEF = 256;
	localparam int unsigned DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	localparam data_t INT_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_PUSH = 2'd1,
		SH_POP  = 2'd2
	} shift_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_SECOND = 1'b1
	} state_t;

	typedef struct packed {
		shift_t shift;
		data_t  push_data;
	} chain_ctl_t;

endpackage

FILE: rtl/core/mts_req_if.sv
interface mts_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

FILE: rtl/core/mts_rsp_if.sv
interface mts_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic signed [31:0] min_out;

	modport source (output valid, output status, output data_out, output min_out, input ready);
	modport sink (input valid, input status, input data_out, input min_out, output ready);
endinterface

FILE: rtl/core/mts_cell.sv
module mts_cell (
	input  logic               clk,
	input  mts_pkg::shift_t    shift,
	input  mts_pkg::data_t     up_data,
	input  mts_pkg::data_t     down_data,
	output mts_pkg::data_t     data
);
	import mts_pkg::*;

	data_t data_q;

	// push moves entries one cell deeper, pop pulls them one cell up
	always_ff @(posedge clk) begin
		case (shift)
			SH_PUSH: data_q <= up_data;
			SH_POP:  data_q <= down_data;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;
endmodule

FILE: rtl/core/mts_ctrl.sv
module mts_ctrl #(
	parameter int unsigned STACK_ENTRIES = mts_pkg::STACK_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mts_req_if.sink                req,
	mts_rsp_if.source              rsp,
	output mts_pkg::chain_ctl_t    chain,
	input  mts_pkg::data_t         top_data
);
	import mts_pkg::*;

	localparam int unsigned DEPTH_W = $clog2(STACK_ENTRIES + 1);
	localparam logic [DEPTH_W-1:0] CAP = DEPTH_W'(STACK_ENTRIES);
	localparam logic [DEPTH_W-1:0] ONE = DEPTH_W'(1);
	localparam logic [DEPTH_W-1:0] TWO = DEPTH_W'(2);

	state_t             state_q, state_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	data_t              min_q, min_d;
	data_t              hold_q, hold_d;
	logic               second_pop_q, second_pop_d;
	logic               out_valid_q;
	status_t            status_q, status_d;
	data_t              data_q, data_d;
	data_t              min_out_q, min_out_d;
	logic               load;

	op_t                req_op;
	data_t              req_val;
	logic               need2;
	logic               full;
	logic               empty;
	logic               hit_min;
	logic               fire;
	logic               go_second;

	assign req_op  = op_t'(req.op);
	assign req_val = req.push_value;
	assign need2   = req_val <= min_q;
	assign full    = depth_q > (CAP - (need2 ? TWO : ONE));
	assign empty   = depth_q == '0;
	assign hit_min = top_data == min_q;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;

	assign go_second = fire &&
		((req_op == OP_PUSH && !full && need2) ||
		 (req_op == OP_POP && !empty && hit_min && depth_q != ONE));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (go_second) state_d = S_SECOND;
			S_SECOND: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		chain.shift     = SH_HOLD;
		chain.push_data = hold_q;
		depth_d         = depth_q;
		min_d           = min_q;
		hold_d          = hold_q;
		second_pop_d    = second_pop_q;
		load            = 1'b0;
		status_d        = ST_OK;
		data_d          = '0;
		min_out_d       = min_q;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					unique case (req_op)
						OP_PUSH: begin
							if (full) begin
								load     = 1'b1;
								status_d = ST_FULL;
							end else if (need2) begin
								// save the old minimum first, value goes on next cycle
								chain.shift     = SH_PUSH;
								chain.push_data = min_q;
								depth_d         = depth_q + ONE;
								min_d           = req_val;
								hold_d          = req_val;
								second_pop_d    = 1'b0;
							end else begin
								chain.shift     = SH_PUSH;
								chain.push_data = req_val;
								depth_d         = depth_q + ONE;
								load            = 1'b1;
							end
						end
						OP_POP: begin
							if (empty) begin
								load     = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								chain.shift = SH_POP;
								depth_d     = depth_q - ONE;
								if (hit_min && depth_q != ONE) begin
									hold_d       = top_data;
									second_pop_d = 1'b1;
								end else if (hit_min) begin
									// no saved minimum beneath
									min_d     = INT_MAX;
									load      = 1'b1;
									data_d    = top_data;
									min_out_d = INT_MAX;
								end else begin
									load   = 1'b1;
									data_d = top_data;
								end
							end
						end
						OP_PEEK: begin
							load = 1'b1;
							if (empty) status_d = ST_EMPTY;
							else       data_d   = top_data;
						end
						default: load = 1'b1;
					endcase
				end
			end
			S_SECOND: begin
				load = 1'b1;
				if (second_pop_q) begin
					// top cell now holds the saved minimum
					chain.shift = SH_POP;
					depth_d     = depth_q - ONE;
					min_d       = top_data;
					data_d      = hold_q;
					min_out_d   = top_data;
				end else begin
					chain.shift     = SH_PUSH;
					chain.push_data = hold_q;
					depth_d         = depth_q + ONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			depth_q      <= '0;
			min_q        <= INT_MAX;
			second_pop_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			depth_q      <= depth_d;
			min_q        <= min_d;
			second_pop_q <= second_pop_d;
			if (load)           out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
		if (load) begin
			status_q  <= status_d;
			data_q    <= data_d;
			min_out_q <= min_out_d;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.data_out = data_q;
	assign rsp.min_out  = min_out_q;

	a_depth_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CAP)
		else $error("stack depth beyond capacity");

	a_no_req_in_second: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SECOND |-> !req.ready)
		else $error("request taken during second step");

	a_second_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SECOND |=> state_q == S_IDLE && out_valid_q)
		else $error("second step did not produce a response");

	a_single_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_op == OP_PUSH && !full && !need2 |=>
			depth_q == $past(depth_q) + ONE)
		else $error("plain push did not grow the stack by one");

	a_output_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !load)
		else $error("response overwritten while stalled");
endmodule

FILE: rtl/core/min_tracking_stack.sv
// Responses: a response is registered when the request is accepted; a push at or below the
// minimum and a pop that restores a saved minimum register theirs in a second step, S_SECOND.
// Throughput: one request per cycle while responses are taken; no request is accepted during
// that second step, since the cell chain shifts by one entry per cycle.
// Reset: depth clears to zero and the minimum to 2147483647; cell contents are not cleared.
module min_tracking_stack #(
	parameter int unsigned STACK_ENTRIES = mts_pkg::STACK_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mts_req_if.sink    req,
	mts_rsp_if.source  rsp
);
	import mts_pkg::*;

	chain_ctl_t chain;
	data_t      cell_data [STACK_ENTRIES];

	mts_ctrl #(
		.STACK_ENTRIES(STACK_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.chain    (chain),
		.top_data (cell_data[0])
	);

	for (genvar i = 0; i < STACK_ENTRIES; i++) begin : g_cell
		data_t up_data;
		data_t down_data;

		if (i == 0) begin : g_top
			assign up_data = chain.push_data;
		end else begin : g_inner_up
			assign up_data = cell_data[i-1];
		end

		if (i == STACK_ENTRIES - 1) begin : g_bottom
			assign down_data = cell_data[i];
		end else begin : g_inner_down
			assign down_data = cell_data[i+1];
		end

		mts_cell u_cell (
			.clk       (clk),
			.shift     (chain.shift),
			.up_data   (up_data),
			.down_data (down_data),
			.data      (cell_data[i])
		);
	end
endmodule
